>>> hdl/histogram_bucket_accumulator_macros.svh
// ----------------------------------------------------------------------------
// histogram bucket accumulator assertion macros
// shared property forms for the checker; clk and rst come from the user scope
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_BUCKET_ACCUMULATOR_MACROS_SVH
`define HISTOGRAM_BUCKET_ACCUMULATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HBA_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define HBA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hba_pkg.sv
// ----------------------------------------------------------------------------
// hba_pkg
// widths, depths, codes and shared types of the histogram bucket accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hba_pkg;

  // geometry
  localparam int SERIES        = 64;
  localparam int MAX_BOUNDS    = 16;
  localparam int BUCKETS       = MAX_BOUNDS + 1;
  localparam int BUCKET_DEPTH  = SERIES * BUCKETS;
  localparam int BUCKET_ADDR_W = $clog2(BUCKET_DEPTH);

  // field widths
  localparam int OPCODE_W = 2;
  localparam int SERIES_W = 6;
  localparam int SLOT_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int BUCKET_W = 5;
  localparam int COUNT_W  = 32;
  localparam int SUM_W    = 48;

  // sum clamp limits
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [OPCODE_W-1:0] {
    OP_RECORD = 2'd0,
    OP_BOUND  = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // one word of the per-series memory
  typedef struct packed {
    logic        [COUNT_W-1:0] count;
    logic signed [SUM_W-1:0]   sum;
    logic signed [VALUE_W-1:0] smallest;
    logic signed [VALUE_W-1:0] largest;
  } series_word_t;

endpackage

>>> hdl/hba_if.sv
// ----------------------------------------------------------------------------
// hba interfaces
// item, result and configuration channels with valid / ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// input item channel
interface hba_item_if
  import hba_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic        [OPCODE_W-1:0] opcode;
  logic        [SERIES_W-1:0] series;
  logic        [SLOT_W-1:0]   bound_slot;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, opcode, series, bound_slot, value, input ready);
  modport sink   (input valid, opcode, series, bound_slot, value, output ready);
endinterface

// result channel
interface hba_result_if
  import hba_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic        [BUCKET_W-1:0] bucket;
  logic        [COUNT_W-1:0]  bucket_total;
  logic        [COUNT_W-1:0]  sample_count;
  logic signed [SUM_W-1:0]    value_sum;
  logic signed [VALUE_W-1:0]  smallest;
  logic signed [VALUE_W-1:0]  largest;

  modport source (output valid, bucket, bucket_total, sample_count, value_sum,
                  smallest, largest, input ready);
  modport sink   (input valid, bucket, bucket_total, sample_count, value_sum,
                  smallest, largest, output ready);
endinterface

// bound count register write channel
interface hba_cfg_if
  import hba_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bound_count;

  modport source (output valid, bound_count, input ready);
  modport sink   (input valid, bound_count, output ready);
endinterface

>>> hdl/histogram_bucket_accumulator.sv
// ----------------------------------------------------------------------------
// histogram_bucket_accumulator
// explicit-bucket histograms for 64 series: bucket counts in one memory,
// count / sum / min / max per series in a second memory
// ----------------------------------------------------------------------------
//
//   channel     dir  payload                                        transfer
//   item_in     in   opcode, series, bound_slot, value              valid & ready
//   result_out  out  bucket, bucket_total, sample_count, value_sum, valid & ready
//                    smallest, largest
//   cfg         in   bound_count                                    valid & ready
//
// a record reads the memories on the accept edge and is modified and written
// back in the next cycle (ST_UPDATE); a bound write or an unused opcode ends at accept
// a series clear zeroes the 17 bucket words of the series, one bucket word zeroed per cycle
// after reset the whole bucket memory (1088 words) is swept to zero, no item taken
// a stalled result holds in the output register; the next item is taken
// as soon as that register is free or draining
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module histogram_bucket_accumulator
  import hba_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  hba_item_if.sink      item_in,
  hba_result_if.source  result_out,
  hba_cfg_if.sink       cfg
);

  state_t state, state_next;

  logic                      accept;
  logic                      clr_done;
  logic [BUCKET_W-1:0]       bound_count;
  logic signed [VALUE_W-1:0] bounds [MAX_BOUNDS];
  logic                      started [SERIES];

  // bucket memory and sweep pointers
  logic [COUNT_W-1:0]       bucket_mem [BUCKET_DEPTH];
  logic [COUNT_W-1:0]       bkt_rdata;
  logic [BUCKET_ADDR_W-1:0] bkt_raddr;
  logic [BUCKET_ADDR_W-1:0] bkt_base;
  logic [BUCKET_ADDR_W-1:0] clr_addr;
  logic [BUCKET_ADDR_W-1:0] clr_last;

  // series memory
  series_word_t series_mem [SERIES];
  series_word_t ser_rdata;
  series_word_t ser_cur;
  series_word_t ser_new;

  // record held between read and write back
  logic [SERIES_W-1:0]       hold_series;
  logic [BUCKET_ADDR_W-1:0]  hold_addr;
  logic [BUCKET_W-1:0]       hold_bucket;
  logic signed [VALUE_W-1:0] hold_value;
  logic                      hold_started;

  // bucket selection
  logic [BUCKET_W-1:0] nb_eff;
  logic [BUCKET_W-1:0] pick;

  // update arithmetic
  logic [COUNT_W-1:0]      bkt_new;
  logic signed [SUM_W:0]   sum_wide;

  // output register
  logic                      out_valid;
  logic [BUCKET_W-1:0]       out_bucket;
  logic [COUNT_W-1:0]        out_bucket_total;
  series_word_t              out_word;

  assign cfg.ready = 1'b1;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next   = state;
    item_in.ready = 1'b0;
    accept       = 1'b0;
    clr_done     = (clr_addr == clr_last);
    case (state)
      ST_CLEAR: begin
        if (clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_in.ready = !out_valid || result_out.ready;
        accept        = item_in.valid && item_in.ready;
        if (accept) begin
          case (opcode_t'(item_in.opcode))
            OP_RECORD: state_next = ST_UPDATE;
            OP_CLEAR:  state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // bound count in use: zero acts as one, clamp at the table size
  always_comb begin
    if (bound_count == '0) begin
      nb_eff = BUCKET_W'(1);
    end else if (bound_count > BUCKET_W'(MAX_BOUNDS)) begin
      nb_eff = BUCKET_W'(MAX_BOUNDS);
    end else begin
      nb_eff = bound_count;
    end
  end

  // parallel compare against all bounds, lowest matching slot wins
  always_comb begin
    pick = nb_eff;
    for (int i = MAX_BOUNDS - 1; i >= 0; i--) begin
      if ((BUCKET_W'(i) < nb_eff) && (item_in.value <= bounds[i])) begin
        pick = BUCKET_W'(i);
      end
    end
  end

  assign bkt_base  = BUCKET_ADDR_W'(item_in.series) * BUCKET_ADDR_W'(BUCKETS);
  assign bkt_raddr = bkt_base + BUCKET_ADDR_W'(pick);

  // bucket memory: sweep writes zero, update writes the new count
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      bucket_mem[clr_addr] <= '0;
    end else if (state == ST_UPDATE) begin
      bucket_mem[hold_addr] <= bkt_new;
    end
    bkt_rdata <= bucket_mem[bkt_raddr];
  end

  // series memory
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      series_mem[hold_series] <= ser_new;
    end
    ser_rdata <= series_mem[item_in.series];
  end

  // a series not started reads as all zero
  assign ser_cur  = hold_started ? ser_rdata : '0;
  assign bkt_new  = (bkt_rdata == '1) ? bkt_rdata : bkt_rdata + COUNT_W'(1);
  assign sum_wide = $signed({ser_cur.sum[SUM_W-1], ser_cur.sum})
                  + $signed((SUM_W+1)'(hold_value));

  // modify step: saturating counts and sum, running min and max
  always_comb begin
    ser_new.count = (ser_cur.count == '1) ? ser_cur.count
                                          : ser_cur.count + COUNT_W'(1);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      ser_new.sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      ser_new.sum = sum_wide[SUM_W-1:0];
    end
    if (!hold_started || (hold_value < ser_cur.smallest)) begin
      ser_new.smallest = hold_value;
    end else begin
      ser_new.smallest = ser_cur.smallest;
    end
    if (!hold_started || (hold_value > ser_cur.largest)) begin
      ser_new.largest = hold_value;
    end else begin
      ser_new.largest = ser_cur.largest;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bound_count <= BUCKET_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      bound_count <= cfg.bound_count;
    end
  end

  // bound table, no reset
  always_ff @(posedge clk) begin
    if (accept && (opcode_t'(item_in.opcode) == OP_BOUND)) begin
      bounds[item_in.bound_slot] <= item_in.value;
    end
  end

  // series started flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SERIES; i++) begin
        started[i] <= 1'b0;
      end
    end else if (accept && (opcode_t'(item_in.opcode) == OP_RECORD)) begin
      started[item_in.series] <= 1'b1;
    end else if (accept && (opcode_t'(item_in.opcode) == OP_CLEAR)) begin
      started[item_in.series] <= 1'b0;
    end
  end

  // sweep pointers: whole memory after reset, one series on a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_last <= BUCKET_ADDR_W'(BUCKET_DEPTH - 1);
    end else if (accept && (opcode_t'(item_in.opcode) == OP_CLEAR)) begin
      clr_addr <= bkt_base;
      clr_last <= bkt_base + BUCKET_ADDR_W'(BUCKETS - 1);
    end else if ((state == ST_CLEAR) && !clr_done) begin
      clr_addr <= clr_addr + BUCKET_ADDR_W'(1);
    end
  end

  // record held for the write back
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_series  <= item_in.series;
      hold_addr    <= bkt_raddr;
      hold_bucket  <= pick;
      hold_value   <= item_in.value;
      hold_started <= started[item_in.series];
    end
  end

  // output register: record result on update, zero result at accept otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_UPDATE) begin
      out_valid <= 1'b1;
    end else if (accept && (opcode_t'(item_in.opcode) != OP_RECORD)) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      out_bucket       <= hold_bucket;
      out_bucket_total <= bkt_new;
      out_word         <= ser_new;
    end else if (accept && (opcode_t'(item_in.opcode) != OP_RECORD)) begin
      out_bucket       <= '0;
      out_bucket_total <= '0;
      out_word         <= '0;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.bucket       = out_bucket;
  assign result_out.bucket_total = out_bucket_total;
  assign result_out.sample_count = out_word.count;
  assign result_out.value_sum    = out_word.sum;
  assign result_out.smallest     = out_word.smallest;
  assign result_out.largest      = out_word.largest;

endmodule

>>> hdl/hba_checker.sv
// ----------------------------------------------------------------------------
// hba_checker
// port-level checks on the result channel of the histogram bucket accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "histogram_bucket_accumulator_macros.svh"

module hba_checker
  import hba_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic        [BUCKET_W-1:0] bucket,
  input logic        [COUNT_W-1:0]  bucket_total,
  input logic        [COUNT_W-1:0]  sample_count,
  input logic signed [SUM_W-1:0]    value_sum,
  input logic signed [VALUE_W-1:0]  smallest,
  input logic signed [VALUE_W-1:0]  largest
);

  // a stalled result keeps its payload
  `HBA_CHECK_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(bucket) && $stable(bucket_total) && $stable(sample_count) && $stable(value_sum) && $stable(smallest) && $stable(largest), "result changed while stalled")

  // one bucket never counts more than its series
  `HBA_CHECK_NOW(a_bucket_le_count, out_valid, bucket_total <= sample_count, "bucket total above sample count")

  // a recorded series has a nonzero bucket total, a valid bucket, min <= max
  `HBA_CHECK_NOW(a_recorded_sane, out_valid && (sample_count != '0), (bucket_total != '0) && (smallest <= largest) && (bucket <= BUCKET_W'(MAX_BOUNDS)), "inconsistent record result")

  // a result with no samples is all zero
  `HBA_CHECK_NOW(a_zero_result, out_valid && (sample_count == '0), (bucket == '0) && (bucket_total == '0) && (value_sum == '0) && (smallest == '0) && (largest == '0), "nonzero field in empty result")

endmodule

bind histogram_bucket_accumulator hba_checker u_hba_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .bucket       (result_out.bucket),
  .bucket_total (result_out.bucket_total),
  .sample_count (result_out.sample_count),
  .value_sum    (result_out.value_sum),
  .smallest     (result_out.smallest),
  .largest      (result_out.largest)
);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for histogram_bucket_accumulator: a directed table, then
// random phases over several bound counts and bound sets with random idling on
// both channels and two long result stalls; every result is checked against
// a histogram model kept inside the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hba_pkg::*;

  // opcode with no function, must give an all-zero result
  localparam logic [OPCODE_W-1:0] OP_NOOP = 2'd3;

  localparam int     SETTLE_CYCLES = 40;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     PHASE_ITEMS   = 180;
  localparam int     MAX_REPORTS   = 10;
  localparam longint V_LO          = -(longint'(1) <<< 31);
  localparam longint V_HI          = (longint'(1) <<< 31) - 1;
  localparam longint SUM_HI        = (longint'(1) <<< 47) - 1;
  localparam longint SUM_LO        = -(longint'(1) <<< 47);

  typedef struct packed {
    logic        [OPCODE_W-1:0] opcode;
    logic        [SERIES_W-1:0] series;
    logic        [SLOT_W-1:0]   slot;
    logic signed [VALUE_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic        [BUCKET_W-1:0] bucket;
    logic        [COUNT_W-1:0]  bucket_total;
    logic        [COUNT_W-1:0]  sample_count;
    logic signed [SUM_W-1:0]    value_sum;
    logic signed [VALUE_W-1:0]  smallest;
    logic signed [VALUE_W-1:0]  largest;
  } tally_t;

  typedef struct packed {
    item_t  it;
    logic   fixed;
    tally_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hba_item_if   itm ();
  hba_result_if rsp ();
  hba_cfg_if    cfgc ();

  histogram_bucket_accumulator uut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (itm),
    .result_out (rsp),
    .cfg        (cfgc)
  );

  // histogram model state
  logic        [BUCKET_W-1:0] n_bounds_reg;
  logic signed [VALUE_W-1:0]  bound_vals [MAX_BOUNDS];
  logic                       live       [SERIES];
  logic        [COUNT_W-1:0]  bin_count  [SERIES][BUCKETS];
  logic        [COUNT_W-1:0]  n_samples  [SERIES];
  logic signed [SUM_W-1:0]    run_sum    [SERIES];
  logic signed [VALUE_W-1:0]  low_mark   [SERIES];
  logic signed [VALUE_W-1:0]  high_mark  [SERIES];

  tally_t    pending_tallies [$];
  plan_row_t directed_plan   [$];

  logic [BUCKET_W-1:0] phase_counts [9] = '{5'd16, 5'd0, 5'd31, 5'd17, 5'd1, 5'd4, 5'd9,
                                            5'd2, 5'd12};

  int gap_max         = 11;
  int holds_requested = 0;
  int holds_done      = 0;
  int faults          = 0;
  int items_sent      = 0;
  int records_sent    = 0;
  int results_checked = 0;
  int cfg_writes      = 0;

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_series(input int s);
    live[s]      = 1'b0;
    n_samples[s] = '0;
    run_sum[s]   = '0;
    low_mark[s]  = '0;
    high_mark[s] = '0;
    for (int b = 0; b < BUCKETS; b++) bin_count[s][b] = '0;
  endfunction

  function automatic void reset_model();
    n_bounds_reg = 5'd1;
    foreach (bound_vals[k]) bound_vals[k] = '0;
    for (int s = 0; s < SERIES; s++) clear_series(s);
  endfunction

  // apply one item to the model and return the result it must produce
  function automatic tally_t predict_tally(input item_t it);
    tally_t                    t;
    logic signed [VALUE_W-1:0] v;
    int                        s;
    int                        nb;
    int                        b;
    longint                    acc;
    t = '0;
    v = it.value;
    s = it.series;
    case (it.opcode)
      OP_BOUND: bound_vals[it.slot] = v;
      OP_CLEAR: clear_series(s);
      OP_RECORD: begin
        nb = (n_bounds_reg == 0) ? 1 : (n_bounds_reg > MAX_BOUNDS) ? MAX_BOUNDS : n_bounds_reg;
        // downward scan leaves the lowest matching bound, overflow if none
        b = nb;
        for (int k = nb - 1; k >= 0; k--) if (v <= bound_vals[k]) b = k;
        if (!live[s]) begin
          live[s]      = 1'b1;
          low_mark[s]  = v;
          high_mark[s] = v;
        end
        if (bin_count[s][b] != '1) bin_count[s][b]++;
        if (n_samples[s] != '1) n_samples[s]++;
        acc = longint'(run_sum[s]) + longint'(v);
        if (acc > SUM_HI) acc = SUM_HI;
        else if (acc < SUM_LO) acc = SUM_LO;
        run_sum[s] = SUM_W'(acc);
        if (v < low_mark[s]) low_mark[s] = v;
        if (v > high_mark[s]) high_mark[s] = v;
        t.bucket       = BUCKET_W'(b);
        t.bucket_total = bin_count[s][b];
        t.sample_count = n_samples[s];
        t.value_sum    = run_sum[s];
        t.smallest     = low_mark[s];
        t.largest      = high_mark[s];
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic plan_row_t row(input logic [OPCODE_W-1:0] op, input int s, input int slot,
                                    input longint v);
    plan_row_t r;
    r           = '0;
    r.it.opcode = op;
    r.it.series = SERIES_W'(s);
    r.it.slot   = SLOT_W'(slot);
    r.it.value  = VALUE_W'(v);
    return r;
  endfunction

  // row whose result is written out by hand
  function automatic plan_row_t known(input plan_row_t r, input int b, input longint total,
                                      input longint cnt, input longint sum, input longint lo,
                                      input longint hi);
    r.fixed             = 1'b1;
    r.want.bucket       = BUCKET_W'(b);
    r.want.bucket_total = COUNT_W'(total);
    r.want.sample_count = COUNT_W'(cnt);
    r.want.value_sum    = SUM_W'(sum);
    r.want.smallest     = VALUE_W'(lo);
    r.want.largest      = VALUE_W'(hi);
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input plan_row_t r);
    directed_plan = {directed_plan, r};
  endfunction

  function automatic logic signed [VALUE_W-1:0] sample_value();
    int mode;
    mode = $urandom_range(0, 9);
    // mostly on or right next to a bound
    if (mode < 6)
      return bound_vals[$urandom_range(0, MAX_BOUNDS - 1)] + VALUE_W'($urandom_range(0, 4)) - 2;
    if (mode < 8) return $urandom;
    if (mode == 8) return ($urandom_range(0, 1) != 0) ? VALUE_W'(V_HI) : VALUE_W'(V_LO);
    return VALUE_W'($urandom_range(0, 100)) - 50;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    it.series = ($urandom_range(0, 3) != 0) ? SERIES_W'($urandom_range(0, 7))
                                            : SERIES_W'($urandom);
    it.slot   = SLOT_W'($urandom);
    it.value  = sample_value();
    pick      = $urandom_range(0, 99);
    if (pick >= 96) it.opcode = OP_NOOP;
    else if (pick >= 92) it.opcode = OP_CLEAR;
    else if (pick >= 86) it.opcode = OP_BOUND;
    else it.opcode = OP_RECORD;
    return it;
  endfunction

  // offer one item, wait for its transfer, then queue the expected result
  task automatic send_item(input item_t it, input logic fixed = 1'b0, input tally_t want = '0);
    int     gap;
    tally_t due;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      itm.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    itm.valid      <= 1'b1;
    itm.opcode     <= it.opcode;
    itm.series     <= it.series;
    itm.bound_slot <= it.slot;
    itm.value      <= it.value;
    do @(posedge clk); while (!(itm.valid === 1'b1 && itm.ready === 1'b1));
    due = predict_tally(it);
    if (fixed) due = want;
    pending_tallies = {pending_tallies, due};
    items_sent++;
    if (it.opcode == OP_RECORD) records_sent++;
  endtask

  // bound count write, only once the block has drained
  task automatic set_bound_count(input logic [BUCKET_W-1:0] n);
    itm.valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfgc.bound_count <= n;
    cfgc.valid       <= 1'b1;
    do @(posedge clk); while (!(cfgc.valid === 1'b1 && cfgc.ready === 1'b1));
    cfgc.valid   <= 1'b0;
    n_bounds_reg = n;
    cfg_writes++;
  endtask

  // sixteen bound writes, sorted or not, wide or narrow spread
  task automatic load_bounds(input bit ordered, input bit narrow);
    int    fresh [$];
    item_t it;
    repeat (MAX_BOUNDS)
      fresh = {fresh, (narrow ? int'($urandom_range(0, 2000)) - 1000 : int'($urandom))};
    if (ordered) fresh.sort();
    foreach (fresh[k]) begin
      it.opcode = OP_BOUND;
      it.series = SERIES_W'($urandom);
      it.slot   = SLOT_W'(k);
      it.value  = fresh[k];
      send_item(it);
    end
  endtask

  // result side: random stalls, one long hold on request, checking
  initial begin : result_side
    int     stall;
    logic   bad;
    tally_t seen;
    tally_t due;
    rsp.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        seen.bucket       = rsp.bucket;
        seen.bucket_total = rsp.bucket_total;
        seen.sample_count = rsp.sample_count;
        seen.value_sum    = rsp.value_sum;
        seen.smallest     = rsp.smallest;
        seen.largest      = rsp.largest;
        results_checked++;
        if (pending_tallies.size() == 0) begin
          faults++;
          if (faults <= MAX_REPORTS)
            $display("%0t: result transfer with no item pending, bucket %0d count %0d",
                     $time, seen.bucket, seen.sample_count);
        end else begin
          due = pending_tallies.pop_front();
          bad = (seen.bucket !== due.bucket) || (seen.bucket_total !== due.bucket_total) ||
                (seen.sample_count !== due.sample_count) || (seen.value_sum !== due.value_sum) ||
                (seen.smallest !== due.smallest) || (seen.largest !== due.largest);
          if (bad) begin
            faults++;
            if (faults <= MAX_REPORTS) begin
              $display("%0t: mismatch exp bucket %0d total %0d count %0d sum %0d min %0d max %0d",
                       $time, due.bucket, due.bucket_total, due.sample_count, due.value_sum,
                       due.smallest, due.largest);
              $display("%0t:          got bucket %0d total %0d count %0d sum %0d min %0d max %0d",
                       $time, seen.bucket, seen.bucket_total, seen.sample_count, seen.value_sum,
                       seen.smallest, seen.largest);
            end
          end
        end
        stall = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      end
      if (holds_done != holds_requested) begin
        holds_done++;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        stall = 0;
      end
      rsp.ready <= 1'b1;
    end
  end

  // stimulus
  initial begin : stimulus
    item_t     it;
    int        n;
    bit        pressed;
    itm.valid        <= 1'b0;
    itm.opcode       <= OP_RECORD;
    itm.series       <= '0;
    itm.bound_slot   <= '0;
    itm.value        <= '0;
    cfgc.valid       <= 1'b0;
    cfgc.bound_count <= '0;
    reset_model();

    // directed table, bound count still at its reset value of one
    add_row(known(row(OP_BOUND, 0, 0, 100), 0, 0, 0, 0, 0, 0));
    add_row(known(row(OP_RECORD, 0, 0, 50), 0, 1, 1, 50, 50, 50));
    add_row(known(row(OP_RECORD, 0, 0, 101), 1, 1, 2, 151, 50, 101));
    add_row(known(row(OP_RECORD, 0, 0, 100), 0, 2, 3, 251, 50, 101));
    add_row(known(row(OP_RECORD, 63, 0, V_LO), 0, 1, 1, V_LO, V_LO, V_LO));
    add_row(known(row(OP_RECORD, 63, 0, V_HI), 1, 1, 2, -1, V_LO, V_HI));
    add_row(known(row(OP_NOOP, 63, 15, -1), 0, 0, 0, 0, 0, 0));
    add_row(known(row(OP_BOUND, 63, 15, V_HI), 0, 0, 0, 0, 0, 0));
    add_row(known(row(OP_BOUND, 0, 0, V_LO), 0, 0, 0, 0, 0, 0));
    add_row(row(OP_RECORD, 0, 15, V_LO));
    add_row(row(OP_RECORD, 0, 0, V_LO + 1));
    add_row(known(row(OP_CLEAR, 0, 0, 0), 0, 0, 0, 0, 0, 0));
    add_row(known(row(OP_RECORD, 0, 0, 7), 1, 1, 1, 7, 7, 7));
    add_row(known(row(OP_CLEAR, 63, 0, V_HI), 0, 0, 0, 0, 0, 0));
    add_row(known(row(OP_CLEAR, 5, 0, 0), 0, 0, 0, 0, 0, 0));
    add_row(known(row(OP_RECORD, 63, 0, 0), 1, 1, 1, 0, 0, 0));
    add_row(known(row(OP_BOUND, 0, 1, 0), 0, 0, 0, 0, 0, 0));
    add_row(row(OP_RECORD, 1, 0, -5));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[k])
      send_item(directed_plan[k].it, directed_plan[k].fixed, directed_plan[k].want);

    // random phases, one bound count and one bound set each
    foreach (phase_counts[p]) begin
      gap_max = (p % 3 == 0) ? 0 : 11;
      set_bound_count(phase_counts[p]);
      load_bounds(p % 4 != 3, p % 2 == 1);
      n       = 0;
      pressed = 1'b0;
      while (n < PHASE_ITEMS) begin
        if (n == PHASE_ITEMS / 2) gap_max = 11;
        // long result hold while items keep coming
        if (n >= 60 && !pressed && p % 4 == 1) begin
          holds_requested++;
          pressed = 1'b1;
        end
        it = random_item();
        send_item(it);
        if (it.opcode != OP_NOOP) n++;
      end
    end

    // drain and let any stray result show up
    itm.valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d records) under %0d bound counts, with idling and stalls",
             items_sent, records_sent, cfg_writes);
    $display("%0d results checked, %0d faults", results_checked, faults);
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #10_000_000;
    $display("timeout at %0t with %0d results pending", $time, pending_tallies.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/hba_pkg.sv
hdl/hba_if.sv
hdl/histogram_bucket_accumulator.sv
hdl/hba_checker.sv
verif/tb.sv
